// File: sv/cfir_pkg.sv
// Shared constants and types for the complex FIR filter.
package cfir_pkg;

    localparam int NUM_TAPS      = 8;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int COEF_WIDTH    = 16;
    localparam int NUM_COEF_REGS = 8;
    localparam int OUT_WIDTH     = 36;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 2 * COEF_WIDTH;
    localparam int S_TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((2 * OUT_WIDTH + 7) / 8) * 8;

    typedef struct packed {
        logic load;
        logic clear;
    } cfir_ctrl_t;

endpackage

// File: sv/complex_fir_filter.sv
// Top level of the complex FIR filter with conjugated taps.
// Takes one complex sample per clock and returns sum of x[k]*conj(h[k]) over the taps,
// wrapped to 36-bit two's complement; first_sample on s_tuser starts a new vector with an
// empty delay line. When a sample is accepted, it is shifted into the chain of tap cells and
// each cell registers its product with its current coefficient; the products are then added
// in a balanced tree into the output register. The whole pipeline holds while a result waits
// on m_tready. Coefficients are written through the cfg port (index k for tap k, real part in
// the low half); the user must write them only while idle, as the block does not enforce it.
// They apply to the samples already in the delay line.
module complex_fir_filter import cfir_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_re, sample_im
    input  logic                  s_tuser,   // first_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_re, out_im
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0]          coef_reg [NUM_TAPS];
    logic                           prod_valid_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] line_re [NUM_TAPS+1];
    logic signed [SAMPLE_WIDTH-1:0] line_im [NUM_TAPS+1];
    logic signed [OUT_WIDTH-1:0]    prod_re [NUM_TAPS];
    logic signed [OUT_WIDTH-1:0]    prod_im [NUM_TAPS];
    logic signed [OUT_WIDTH-1:0]    tree_re [NUM_TAPS];
    logic signed [OUT_WIDTH-1:0]    tree_im [NUM_TAPS];
    logic signed [OUT_WIDTH-1:0]    sum_re_next, sum_im_next;
    logic signed [OUT_WIDTH-1:0]    sum_re_reg, sum_im_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                coef_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                if (cfg_valid && cfg_index == CFG_IDX_W'(k)) begin
                    coef_reg[k] <= cfg_data;
                end
            end
        end
    end

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = advance && s_tvalid;

    assign line_re[0] = signed'(s_tdata[SAMPLE_WIDTH-1:0]);
    assign line_im[0] = signed'(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);

    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
        cfir_ctrl_t cell_ctrl;

        assign cell_ctrl.load  = accept;
        assign cell_ctrl.clear = (k != 0) && s_tuser;

        cfir_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .x_in_re     (line_re[k]),
            .x_in_im     (line_im[k]),
            .coef        (coef_reg[k]),
            .x_out_re    (line_re[k+1]),
            .x_out_im    (line_im[k+1]),
            .prod_out_re (prod_re[k]),
            .prod_out_im (prod_im[k])
        );
    end

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            tree_re[k] = prod_re[k];
            tree_im[k] = prod_im[k];
        end
        for (int span = 1; span < NUM_TAPS; span = span * 2) begin
            for (int k = 0; k + span < NUM_TAPS; k = k + 2 * span) begin
                tree_re[k] = tree_re[k] + tree_re[k + span];
                tree_im[k] = tree_im[k] + tree_im[k + span];
            end
        end
    end

    assign sum_re_next = tree_re[0];
    assign sum_im_next = tree_im[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_re_reg     <= '0;
            sum_im_reg     <= '0;
        end else if (advance) begin
            prod_valid_reg <= s_tvalid;
            out_valid_reg  <= prod_valid_reg;
            if (prod_valid_reg) begin
                sum_re_reg <= sum_re_next;
                sum_im_reg <= sum_im_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({sum_im_reg, sum_re_reg});

`ifndef ASSERT_OFF
    a_stall_holds_product: assert property (@(posedge aclk) disable iff (!aresetn)
        prod_valid_reg && !advance |=> prod_valid_reg)
        else $error("product stage lost a word during stall");

    a_shift_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && prod_valid_reg |=> m_tvalid)
        else $error("product stage did not present a result");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !prod_valid_reg)
        else $error("pipeline not empty after reset");

    a_reset_clears_line: assert property (@(posedge aclk)
        !aresetn |=> line_re[NUM_TAPS] == '0 && line_im[NUM_TAPS] == '0)
        else $error("delay line not cleared by reset");
`endif

endmodule

// File: sv/cfir_cell.sv
// One tap cell: delay-line sample register and conjugate product register.
module cfir_cell import cfir_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cfir_ctrl_t                     ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in_re,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in_im,
    input  logic        [CFG_DATA_W-1:0]   coef,
    output logic signed [SAMPLE_WIDTH-1:0] x_out_re,
    output logic signed [SAMPLE_WIDTH-1:0] x_out_im,
    output logic signed [OUT_WIDTH-1:0]    prod_out_re,
    output logic signed [OUT_WIDTH-1:0]    prod_out_im
);

    localparam int MUL_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int PROD_W = MUL_W + 1;
    localparam int WIDE_W = (PROD_W > OUT_WIDTH) ? PROD_W : OUT_WIDTH;

    function automatic logic signed [OUT_WIDTH-1:0] fit_out(input logic signed [PROD_W-1:0] v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[OUT_WIDTH-1:0];
    endfunction

    logic signed [COEF_WIDTH-1:0]   h_re;
    logic signed [COEF_WIDTH-1:0]   h_im;
    logic signed [SAMPLE_WIDTH-1:0] x_re_next, x_im_next;
    logic signed [SAMPLE_WIDTH-1:0] x_re_reg, x_im_reg;
    logic signed [MUL_W-1:0]        m_rr, m_ii, m_ir, m_ri;
    logic signed [PROD_W-1:0]       prod_re_next, prod_im_next;
    logic signed [PROD_W-1:0]       prod_re_reg, prod_im_reg;

    assign h_re = signed'(coef[COEF_WIDTH-1:0]);
    assign h_im = signed'(coef[CFG_DATA_W-1:COEF_WIDTH]);

    assign x_re_next = ctrl.clear ? '0 : x_in_re;
    assign x_im_next = ctrl.clear ? '0 : x_in_im;

    assign m_rr = x_re_next * h_re;
    assign m_ii = x_im_next * h_im;
    assign m_ir = x_im_next * h_re;
    assign m_ri = x_re_next * h_im;

    assign prod_re_next = PROD_W'(m_rr) + PROD_W'(m_ii);
    assign prod_im_next = PROD_W'(m_ir) - PROD_W'(m_ri);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_re_reg <= '0;
            x_im_reg <= '0;
        end else if (ctrl.load) begin
            x_re_reg <= x_re_next;
            x_im_reg <= x_im_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
    end

    assign x_out_re    = x_re_reg;
    assign x_out_im    = x_im_reg;
    assign prod_out_re = fit_out(prod_re_reg);
    assign prod_out_im = fit_out(prod_im_reg);

endmodule

// File: test/tb.sv
// Self-checking testbench for complex_fir_filter: predicts each output word and compares it.
module tb;
    import cfir_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] im;
        logic [OUT_WIDTH-1:0] re;
    } fir_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [M_TDATA_W-1:0]   m_tdata;
    wire                   cfg_ready;

    logic [CFG_DATA_W-1:0]          tap_coef [NUM_COEF_REGS] = '{default: '0};
    logic signed [SAMPLE_WIDTH-1:0] line_re [NUM_TAPS] = '{default: '0};
    logic signed [SAMPLE_WIDTH-1:0] line_im [NUM_TAPS] = '{default: '0};
    fir_out_t                       pending_out [$];

    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int unsigned hold_len       = 0;
    int unsigned hold_seq       = 0;
    int          errors         = 0;
    int          cycle_count    = 0;

    complex_fir_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTED) begin
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    // shift one sample in and sum x[k] * conj(h[k]) over the taps
    function automatic fir_out_t fir_predict(input logic signed [SAMPLE_WIDTH-1:0] xre,
                                             input logic signed [SAMPLE_WIDTH-1:0] xim,
                                             input logic first);
        longint   acc_re;
        longint   acc_im;
        longint   xr;
        longint   xi;
        longint   hr;
        longint   hi;
        fir_out_t r;
        acc_re = 0;
        acc_im = 0;
        if (first) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                line_re[k] = '0;
                line_im[k] = '0;
            end
        end
        for (int k = NUM_TAPS - 1; k > 0; k--) begin
            line_re[k] = line_re[k-1];
            line_im[k] = line_im[k-1];
        end
        line_re[0] = xre;
        line_im[0] = xim;
        for (int k = 0; k < NUM_TAPS; k++) begin
            xr = line_re[k];
            xi = line_im[k];
            hr = $signed(tap_coef[k][COEF_WIDTH-1:0]);
            hi = $signed(tap_coef[k][2*COEF_WIDTH-1:COEF_WIDTH]);
            acc_re += xr * hr + xi * hi;
            acc_im += xi * hr - xr * hi;
        end
        r.re = acc_re[OUT_WIDTH-1:0];
        r.im = acc_im[OUT_WIDTH-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        fir_out_t got;
        fir_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_COEF_REGS) begin
                tap_coef[cfg_index] = cfg_data;
            end
            if (s_tvalid && s_tready) begin
                pending_out.push_back(fir_predict(s_tdata[SAMPLE_WIDTH-1:0],
                                                  s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH],
                                                  s_tuser));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[2*OUT_WIDTH-1:0];
                if (pending_out.size() == 0) begin
                    report_error("output word with no sample pending");
                end else begin
                    want = pending_out.pop_front();
                    if (got.re !== want.re) begin
                        report_error($sformatf("out_re got %h expected %h", got.re, want.re));
                    end
                    if (got.im !== want.im) begin
                        report_error($sformatf("out_im got %h expected %h", got.im, want.im));
                    end
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold when one is requested
    initial begin
        int unsigned seen_seq;
        int unsigned hold_left;
        seen_seq  = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != seen_seq) begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    function automatic logic [SAMPLE_WIDTH-1:0] rand_component();
        case ($urandom_range(15))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] re,
                               input logic [SAMPLE_WIDTH-1:0] im,
                               input logic first);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // write every tap, with ignored writes to indexes past the last tap mixed in
    task automatic program_taps(input logic [CFG_DATA_W-1:0] coefs [NUM_COEF_REGS]);
        for (int k = 0; k < NUM_COEF_REGS; k++) begin
            write_coef(CFG_IDX_W'(k), coefs[k]);
            if ($urandom_range(1)) begin
                write_coef(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, NUM_COEF_REGS)), $urandom);
            end
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_taps();
        logic [CFG_DATA_W-1:0] coefs [NUM_COEF_REGS];
        for (int k = 0; k < NUM_COEF_REGS; k++) begin
            coefs[k] = {rand_component(), rand_component()};
        end
        program_taps(coefs);
    endtask

    task automatic test_reset_taps();
        push_sample(16'sh8000, 16'sh7FFF, 1'b1);
        push_sample(16'sh7FFF, 16'sh8000, 1'b0);
        push_sample(SAMPLE_WIDTH'($urandom), SAMPLE_WIDTH'($urandom), 1'b0);
        wait_idle();
    endtask

    // largest magnitude everywhere: the guard bits must hold the full sum
    task automatic test_extreme_taps();
        logic [CFG_DATA_W-1:0] coefs [NUM_COEF_REGS];
        coefs = '{default: 32'h8000_8000};
        program_taps(coefs);
        for (int i = 0; i < NUM_TAPS; i++) begin
            push_sample(16'sh8000, 16'sh8000, i == 0);
        end
        push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        push_sample(16'sh7FFF, 16'sh8000, 1'b1);
        wait_idle();
    endtask

    // impulse walks through each tap; a new vector mid-stream clears the line
    task automatic test_impulse();
        logic [CFG_DATA_W-1:0] coefs [NUM_COEF_REGS];
        for (int k = 0; k < NUM_COEF_REGS; k++) begin
            coefs[k] = $urandom;
        end
        coefs[0]                 = 32'h7FFF_7FFF;
        coefs[NUM_COEF_REGS - 1] = 32'h7FFF_8000;
        program_taps(coefs);
        push_sample(16'sh7FFF, '0, 1'b1);
        for (int i = 1; i < NUM_TAPS; i++) begin
            push_sample('0, '0, 1'b0);
        end
        push_sample('0, 16'sh8000, 1'b1);
        wait_idle();
    endtask

    // new taps apply to the samples already held in the delay line
    task automatic test_retap();
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        random_taps();
        for (int i = 0; i < 6; i++) begin
            push_sample(rand_component(), rand_component(), i == 0);
        end
        wait_idle();
        random_taps();
        for (int i = 0; i < 6; i++) begin
            push_sample(rand_component(), rand_component(), 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_random_phase(input int src_pct, input int sink_pct, input int n);
        int run_left;
        run_left     = 0;
        src_idle_pct = src_pct;
        sink_stall_pct <= sink_pct;
        random_taps();
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(40, 1);
                push_sample(rand_component(), rand_component(), 1'b1);
            end else begin
                push_sample(rand_component(), rand_component(), $urandom_range(19) == 0);
            end
            run_left--;
        end
        wait_idle();
    endtask

    // hold the output long enough that the pipeline fills and the input stalls
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        random_taps();
        hold_len <= 300;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 60; i++) begin
            push_sample(rand_component(), rand_component(), i == 0);
        end
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_taps();
        test_extreme_taps();
        test_impulse();
        test_retap();
        test_random_phase(0, 0, 200);
        test_random_phase(81, 0, 200);
        test_random_phase(0, 81, 200);
        test_random_phase(12, 12, 200);
        test_backpressure();
        if (errors == 0 && pending_out.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
